@@ rtl/core/srt_pkg.sv @@
package srt_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ID_W    = 31;
    localparam int CLS_W   = 8;
    localparam int GRD_W   = 10;
    localparam int SUM_W   = 12;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // One held record; the grade sum is kept alongside as the sort key.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CLS_W-1:0]   cls;
        logic [3*GRD_W-1:0] grades;
        logic [SUM_W-1:0]   sum;
    } t_rec;

    // Command broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic del_en;
        t_rec rec;
    } t_cmd;

endpackage

@@ rtl/core/sorted_record_table.sv @@
// Channel  Direction  Handshake           Payload
// command  in         start & !busy       i_func, i_student_id, i_class_code, i_grade_*
// result   out        o_done (one cycle)  o_status, o_entry_count
//
// Each cell compares the broadcast key and shifts its record in the same
// cycle, so busy stays low and a new command may follow in every cycle.
// The result is registered and appears in the cycle after the transfer.
// Reset (synchronous, active low) empties the table; record contents are not
// cleared. The receiver cannot stall; results are not held.
module sorted_record_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [srt_pkg::ID_W-1:0]      i_student_id,
    input  logic [srt_pkg::CLS_W-1:0]     i_class_code,
    input  logic [srt_pkg::GRD_W-1:0]     i_grade_one,
    input  logic [srt_pkg::GRD_W-1:0]     i_grade_two,
    input  logic [srt_pkg::GRD_W-1:0]     i_grade_three,
    output logic                          o_done,
    output logic [srt_pkg::STAT_W-1:0]    o_status,
    output logic [srt_pkg::ENTRY_W-1:0]   o_entry_count
);
    import srt_pkg::*;

    t_cmd             w_cmd;
    t_rec             w_rec   [DEPTH];
    logic             w_lt    [DEPTH];
    logic             w_found [DEPTH];
    logic             w_accept;
    logic             w_full;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [STAT_W-1:0] n_status;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_fill == CNT_W'(DEPTH));

    always_comb begin
        w_cmd.rec.id     = i_student_id;
        w_cmd.rec.cls    = i_class_code;
        w_cmd.rec.grades = {i_grade_three, i_grade_two, i_grade_one};
        w_cmd.rec.sum    = SUM_W'(i_grade_one) + SUM_W'(i_grade_two)
                         + SUM_W'(i_grade_three);
        w_cmd.ins_en     = w_accept && (i_func == FUNC_INSERT) && !w_full;
        w_cmd.del_en     = w_accept && (i_func == FUNC_REMOVE);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_rec w_left_rec;
        t_rec w_right_rec;
        logic w_left_lt;
        logic w_found_in;

        if (g == 0) begin : g_head
            assign w_left_rec = w_cmd.rec;
            assign w_left_lt  = 1'b1;
            assign w_found_in = 1'b0;
        end else begin : g_body
            assign w_left_rec = w_rec[g-1];
            assign w_left_lt  = w_lt[g-1];
            assign w_found_in = w_found[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_rec = w_rec[g];
        end else begin : g_mid
            assign w_right_rec = w_rec[g+1];
        end

        srt_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_valid     (CNT_W'(g) < r_fill),
            .i_left_rec  (w_left_rec),
            .i_left_lt   (w_left_lt),
            .i_right_rec (w_right_rec),
            .i_found     (w_found_in),
            .o_rec       (w_rec[g]),
            .o_lt        (w_lt[g]),
            .o_found     (w_found[g])
        );
    end

    always_comb begin
        n_fill   = r_fill;
        n_status = ST_OK;
        if (i_func == FUNC_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_fill = r_fill + CNT_W'(1);
            end
        end else begin
            if (r_fill == '0) begin
                n_status = ST_EMPTY;
            end else if (!w_found[DEPTH-1]) begin
                n_status = ST_NOT_FOUND;
            end else begin
                n_fill = r_fill - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= w_accept;
            if (w_accept) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_status      <= n_status;
            o_entry_count <= ENTRY_W'(n_fill);
        end
    end

endmodule

@@ rtl/core/srt_cell.sv @@
module srt_cell (
    input  logic          i_clk,
    input  srt_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    input  srt_pkg::t_rec i_left_rec,
    input  logic          i_left_lt,
    input  srt_pkg::t_rec i_right_rec,
    input  logic          i_found,
    output srt_pkg::t_rec o_rec,
    output logic          o_lt,
    output logic          o_found
);
    import srt_pkg::*;

    t_rec r_rec;
    t_rec n_rec;
    logic w_match;

    assign o_lt    = i_valid && (r_rec.sum < i_cmd.rec.sum);
    assign w_match = i_valid && (r_rec.id == i_cmd.rec.id);
    assign o_found = i_found || w_match;
    assign o_rec   = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_cmd.ins_en && !o_lt) begin
            // first cell not below the key takes the new record, later ones shift right
            n_rec = i_left_lt ? i_cmd.rec : i_left_rec;
        end else if (i_cmd.del_en && o_found) begin
            // close the gap from the first match onward
            n_rec = i_right_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule
